FILE: src/palindromic_tree_max_score_macros.svh
// assertion macros for the palindromic tree score block
// taken in by the files that carry concurrent assertions, no other dependency
`ifndef PALINDROMIC_TREE_MAX_SCORE_MACROS_SVH
`define PALINDROMIC_TREE_MAX_SCORE_MACROS_SVH
`ifndef SYNTH
`define PTMS_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptms assertion failed");
`define PTMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptms assertion failed");
`else
`define PTMS_ASSERT(label, clk, rst_n, ante, cons)
`define PTMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/ptms_pkg.sv
// shared constants and types of the palindromic tree score block
// no dependencies
package ptms_pkg;

    localparam int MAX_LEN_DEF  = 4096;
    localparam int ALPHABET_DEF = 26;
    localparam int LETTER_W     = 5;
    localparam int SCORE_W      = 25;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // control of the child table write port
    typedef struct packed {
        logic wr;   // write one entry
        logic clr;  // clear one entry
    } t_child_ctl;

endpackage

FILE: src/ptms_if.sv
// handshake channels of the palindromic tree score block
// depends on ptms_pkg
interface ptms_in_if import ptms_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [LETTER_W-1:0] letter;
    logic                last;
    modport source (output valid, output letter, output last, input ready);
    modport sink   (input valid, input letter, input last, output ready);
endinterface

interface ptms_out_if import ptms_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SCORE_W-1:0] best_score;
    logic               overflow;
    modport source (output valid, output best_score, output overflow, input ready);
    modport sink   (input valid, input best_score, input overflow, output ready);
endinterface

FILE: src/ptms_child_mem.sv
// child table: one row per node, one entry per letter, synchronous read
// depends on ptms_pkg for the write control struct
module ptms_child_mem import ptms_pkg::*; #(
    parameter int ROWS = MAX_LEN_DEF + 2,
    parameter int COLS = ALPHABET_DEF,
    parameter int RW   = $clog2(ROWS),
    parameter int CW   = (COLS > 1) ? $clog2(COLS) : 1,
    parameter int DW   = RW
) (
    input  logic          i_clk,
    input  t_child_ctl    i_ctl,
    input  logic [RW-1:0] i_wrow,
    input  logic [CW-1:0] i_wcol,
    input  logic [DW-1:0] i_wdata,
    input  logic [RW-1:0] i_rrow,
    input  logic [CW-1:0] i_rcol,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [ROWS][COLS];
    logic [DW-1:0] r_q;

    // a clear wins over an entry write
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            mem[i_wrow][i_wcol] <= '0;
        end else if (i_ctl.wr) begin
            mem[i_wrow][i_wcol] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= mem[i_rrow][i_rcol];
    end

    assign o_rdata = r_q;

endmodule

FILE: src/palindromic_tree_max_score.sv
// top level of the palindromic tree score block
// depends on ptms_pkg, ptms_if, ptms_child_mem and the assertion macro header
//
// Builds a palindromic tree over a lower-case string that arrives one letter
// per input beat, and on the beat marked last emits the largest occurrence
// count times length over all distinct palindromes, then clears for the next
// string. All tree state sits in synchronous memories (text, child table,
// node link, length, parent and letter, occurrence count), and a sequencer
// works on one letter at a time. A letter goes through an accept step, then
// per suffix-link step a node memory read, a text memory read and a compare,
// then one child table read, a second link walk when a new node of length
// two or more is made, and the count read-modify-write. A dropped letter
// past MAX_LEN takes the accept step only.
// The last letter adds the count push-down over the tree nodes (read node
// and count, read suffix link count, accumulate), a clear of the two roots
// and the result beat; the push-down clears each node's own child entry and
// its count on its way, so no separate sweep is needed between strings.
// After reset a clearing pass over every child entry runs before the first
// letter is taken. Letters beyond MAX_LEN are dropped and flag overflow;
// letter codes at or above ALPHABET are folded modulo ALPHABET.
`include "palindromic_tree_max_score_macros.svh"

module palindromic_tree_max_score import ptms_pkg::*; #(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ptms_in_if.sink      i_in,
    ptms_out_if.source   o_out
);

    localparam int NODE_CAP = MAX_LEN + 2;
    localparam int NW       = $clog2(NODE_CAP);       // node index, length plus one
    localparam int PW       = $clog2(MAX_LEN + 1);    // text position, counts
    localparam int CW       = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int PRW      = PW + NW;
    localparam int EXW      = PRW + SCORE_W;
    localparam logic [NW-1:0] NODE_LAST = NW'(NODE_CAP - 1);
    localparam logic [PW-1:0] MAX_POS   = PW'(MAX_LEN);
    localparam logic [CW-1:0] COL_LAST  = CW'(ALPHABET - 1);

    // sequencer states
    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_WN   = 4'd2;   // read node link and length
    localparam logic [3:0] S_WT   = 4'd3;   // read text before the palindrome
    localparam logic [3:0] S_WC   = 4'd4;   // compare, read child entry
    localparam logic [3:0] S_CD   = 4'd5;   // child entry available
    localparam logic [3:0] S_IR   = 4'd6;   // read count
    localparam logic [3:0] S_IW   = 4'd7;   // write count plus one
    localparam logic [3:0] S_FR   = 4'd8;   // push-down: read node and count
    localparam logic [3:0] S_FL   = 4'd9;   // push-down: read suffix link count
    localparam logic [3:0] S_FA   = 4'd10;  // push-down: accumulate, score
    localparam logic [3:0] S_CLR0 = 4'd11;
    localparam logic [3:0] S_CLR1 = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    typedef struct packed {
        logic [NW-1:0] link;
        logic [NW-1:0] lp;     // palindrome length plus one
        logic [NW-1:0] par;    // node whose child entry points here
        logic [CW-1:0] ch;     // letter of that child entry
    } t_node;

    // letter folding table, worked out at elaboration
    logic [CW-1:0] mod_tab [32];
    for (genvar g = 0; g < 32; g++) begin : g_mod
        assign mod_tab[g] = CW'(g % ALPHABET);
    end

    // memories
    logic [CW-1:0] text_mem [MAX_LEN + 1];
    t_node         node_mem [NODE_CAP];
    logic [PW-1:0] cnt_mem  [NODE_CAP];

    logic [CW-1:0] r_text_q;
    t_node         r_node_q;
    logic [PW-1:0] r_cnt_q;
    logic [NW-1:0] child_q;

    // memory port controls
    logic          text_we;
    logic [PW-1:0] text_waddr, text_raddr;
    logic [CW-1:0] text_wdata;
    logic          node_we;
    logic [NW-1:0] node_waddr, node_raddr;
    t_node         node_wdata;
    logic          cnt_we;
    logic [NW-1:0] cnt_waddr, cnt_raddr;
    logic [PW-1:0] cnt_wdata;
    t_child_ctl    child_ctl;
    logic [NW-1:0] child_wrow;
    logic [CW-1:0] child_wcol;
    logic [NW-1:0] child_wdata;

    // registers and next values
    logic [3:0]         r_state, n_state;
    logic [CW-1:0]      r_c, n_c;
    logic               r_last, n_last;
    logic [PW-1:0]      r_pos, n_pos;
    logic [NW-1:0]      r_cur, n_cur;
    logic [NW-1:0]      r_total, n_total;
    logic               r_ovf, n_ovf;
    logic [NW-1:0]      r_nd, n_nd;
    logic [NW-1:0]      r_lp, n_lp;
    logic [NW-1:0]      r_link, n_link;
    logic               r_ok, n_ok;
    logic               r_sub, n_sub;
    logic [NW-1:0]      r_par, n_par;
    logic [NW-1:0]      r_par_lp, n_par_lp;
    logic [NW-1:0]      r_nx, n_nx;
    logic [NW-1:0]      r_k, n_k;
    logic [PW-1:0]      r_cnt, n_cnt;
    logic [PRW-1:0]     r_prod, n_prod;
    logic               r_pv, n_pv;
    logic [SCORE_W-1:0] r_best, n_best;
    logic [NW-1:0]      r_init, n_init;
    logic [CW-1:0]      r_init_col, n_init_col;
    logic               r_ovalid, n_ovalid;
    logic [SCORE_W-1:0] r_obest, n_obest;
    logic               r_oovf, n_oovf;

    logic               accept;
    logic [NW-1:0]      idx_w;
    logic [NW-1:0]      nx_new;
    logic [NW-1:0]      k_dec;
    logic [EXW-1:0]     prod_ext;
    logic [SCORE_W-1:0] prod_sat;
    logic [SCORE_W-1:0] fold_best;

    assign accept = i_in.valid && i_in.ready;
    assign idx_w  = NW'(r_pos) - r_node_q.lp;
    assign nx_new = r_total + 1'b1;
    assign k_dec  = r_k - 1'b1;

    // saturate the registered product and fold it into the running best
    assign prod_ext  = EXW'(r_prod);
    assign prod_sat  = (prod_ext > EXW'(SCORE_MAX)) ? SCORE_MAX : prod_ext[SCORE_W-1:0];
    assign fold_best = (r_pv && prod_sat > r_best) ? prod_sat : r_best;

    always_comb begin
        n_state    = r_state;
        n_c        = r_c;
        n_last     = r_last;
        n_pos      = r_pos;
        n_cur      = r_cur;
        n_total    = r_total;
        n_ovf      = r_ovf;
        n_nd       = r_nd;
        n_lp       = r_lp;
        n_link     = r_link;
        n_ok       = r_ok;
        n_sub      = r_sub;
        n_par      = r_par;
        n_par_lp   = r_par_lp;
        n_nx       = r_nx;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_prod     = r_prod;
        n_pv       = r_pv;
        n_best     = r_best;
        n_init     = r_init;
        n_init_col = r_init_col;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_obest    = r_obest;
        n_oovf     = r_oovf;

        text_we     = 1'b0;
        text_waddr  = r_pos + 1'b1;
        text_wdata  = mod_tab[i_in.letter];
        text_raddr  = idx_w[PW-1:0];
        node_we     = 1'b0;
        node_waddr  = r_nx;
        node_wdata  = '{link: r_link, lp: r_par_lp + NW'(2), par: r_par, ch: r_c};
        node_raddr  = r_nd;
        cnt_we      = 1'b0;
        cnt_waddr   = r_nx;
        cnt_wdata   = r_cnt_q + 1'b1;
        cnt_raddr   = r_nx;
        child_ctl   = '{wr: 1'b0, clr: 1'b0};
        child_wrow  = r_par;
        child_wcol  = r_c;
        child_wdata = r_nx;

        unique case (r_state)
            S_INIT: begin
                // clear every child entry one at a time, every count, set up both roots
                child_ctl  = '{wr: 1'b0, clr: 1'b1};
                child_wrow = r_init;
                child_wcol = r_init_col;
                cnt_we     = 1'b1;
                cnt_waddr  = r_init;
                cnt_wdata  = '0;
                node_we    = 1'b1;
                node_waddr = r_init;
                node_wdata = '{link: '0, lp: (r_init == NW'(1)) ? NW'(1) : '0,
                               par: '0, ch: '0};
                if (r_init_col == COL_LAST) begin
                    n_init_col = '0;
                    if (r_init == NODE_LAST) begin
                        n_state = S_IDLE;
                    end else begin
                        n_init = r_init + 1'b1;
                    end
                end else begin
                    n_init_col = r_init_col + 1'b1;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_last = i_in.last;
                    n_c    = mod_tab[i_in.letter];
                    if (r_pos < MAX_POS) begin
                        text_we = 1'b1;
                        n_pos   = r_pos + 1'b1;
                        n_nd    = r_cur;
                        n_sub   = 1'b0;
                        n_state = S_WN;
                    end else begin
                        n_ovf = 1'b1;
                        if (i_in.last) begin
                            n_k     = r_total;
                            n_pv    = 1'b0;
                            n_state = (r_total > NW'(1)) ? S_FR : S_CLR0;
                        end
                    end
                end
            end
            S_WN: begin
                node_raddr = r_nd;
                n_state    = S_WT;
            end
            S_WT: begin
                // text index is position minus length minus one
                n_lp    = r_node_q.lp;
                n_link  = r_node_q.link;
                n_ok    = NW'(r_pos) > r_node_q.lp;
                n_state = S_WC;
            end
            S_WC: begin
                if (r_ok && r_text_q == r_c) begin
                    if (!r_sub) begin
                        n_par    = r_nd;
                        n_par_lp = r_lp;
                    end
                    n_state = S_CD;
                end else begin
                    n_nd    = r_link;
                    n_state = S_WN;
                end
            end
            S_CD: begin
                if (r_sub) begin
                    // second walk done: child of the shorter suffix is the link
                    node_we     = 1'b1;
                    node_waddr  = r_nx;
                    node_wdata  = '{link: (child_q != '0) ? child_q : NW'(1),
                                    lp: r_par_lp + NW'(2), par: r_par, ch: r_c};
                    child_ctl   = '{wr: 1'b1, clr: 1'b0};
                    child_wrow  = r_par;
                    child_wdata = r_nx;
                    n_sub       = 1'b0;
                    n_state     = S_IR;
                end else if (child_q != '0) begin
                    n_nx    = child_q;
                    n_state = S_IR;
                end else if (r_total != NODE_LAST) begin
                    n_nx    = nx_new;
                    n_total = nx_new;
                    if (r_par == '0) begin
                        // single letter palindrome links to the empty root
                        node_we     = 1'b1;
                        node_waddr  = nx_new;
                        node_wdata  = '{link: NW'(1), lp: r_par_lp + NW'(2),
                                        par: r_par, ch: r_c};
                        child_ctl   = '{wr: 1'b1, clr: 1'b0};
                        child_wrow  = r_par;
                        child_wdata = nx_new;
                        n_state     = S_IR;
                    end else begin
                        n_sub   = 1'b1;
                        n_nd    = r_link;
                        n_state = S_WN;
                    end
                end else begin
                    // tree full: the occurrence goes to the empty root
                    n_nx    = NW'(1);
                    n_state = S_IR;
                end
            end
            S_IR: begin
                cnt_raddr = r_nx;
                n_state   = S_IW;
            end
            S_IW: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_nx;
                cnt_wdata = r_cnt_q + 1'b1;
                n_cur     = r_nx;
                if (r_last) begin
                    n_k     = r_total;
                    n_pv    = 1'b0;
                    n_state = (r_total > NW'(1)) ? S_FR : S_CLR0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FR: begin
                node_raddr = r_k;
                cnt_raddr  = r_k;
                n_best     = fold_best;
                n_pv       = 1'b0;
                n_state    = S_FL;
            end
            S_FL: begin
                // clear the one child entry that points at this node
                n_link     = r_node_q.link;
                n_lp       = r_node_q.lp;
                n_cnt      = r_cnt_q;
                cnt_raddr  = r_node_q.link;
                cnt_we     = 1'b1;
                cnt_waddr  = r_k;
                cnt_wdata  = '0;
                child_ctl  = '{wr: 1'b0, clr: 1'b1};
                child_wrow = r_node_q.par;
                child_wcol = r_node_q.ch;
                n_state    = S_FA;
            end
            S_FA: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_link;
                cnt_wdata = r_cnt_q + r_cnt;
                n_prod    = PRW'(r_cnt) * PRW'(r_lp - 1'b1);
                n_pv      = 1'b1;
                n_k       = k_dec;
                n_state   = (k_dec > NW'(1)) ? S_FR : S_CLR0;
            end
            S_CLR0: begin
                n_best     = fold_best;
                n_pv       = 1'b0;
                cnt_we     = 1'b1;
                cnt_waddr  = '0;
                cnt_wdata  = '0;
                n_state    = S_CLR1;
            end
            S_CLR1: begin
                cnt_we     = 1'b1;
                cnt_waddr  = NW'(1);
                cnt_wdata  = '0;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_obest  = r_best;
                    n_oovf   = r_ovf;
                    n_best   = '0;
                    n_ovf    = 1'b0;
                    n_pos    = '0;
                    n_cur    = NW'(1);
                    n_total  = NW'(1);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state    = S_INIT;
                n_init     = '0;
                n_init_col = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_init     <= '0;
            r_init_col <= '0;
            r_pos      <= '0;
            r_cur      <= NW'(1);
            r_total    <= NW'(1);
            r_ovf      <= 1'b0;
            r_sub      <= 1'b0;
            r_pv       <= 1'b0;
            r_best     <= '0;
            r_last     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_init     <= n_init;
            r_init_col <= n_init_col;
            r_pos      <= n_pos;
            r_cur      <= n_cur;
            r_total    <= n_total;
            r_ovf      <= n_ovf;
            r_sub      <= n_sub;
            r_pv       <= n_pv;
            r_best     <= n_best;
            r_last     <= n_last;
            r_ovalid   <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_c      <= n_c;
        r_nd     <= n_nd;
        r_lp     <= n_lp;
        r_link   <= n_link;
        r_ok     <= n_ok;
        r_par    <= n_par;
        r_par_lp <= n_par_lp;
        r_nx     <= n_nx;
        r_k      <= n_k;
        r_cnt    <= n_cnt;
        r_prod   <= n_prod;
        r_obest  <= n_obest;
        r_oovf   <= n_oovf;
    end

    // text, node and count memories
    always_ff @(posedge i_clk) begin
        if (text_we) begin
            text_mem[text_waddr] <= text_wdata;
        end
        r_text_q <= text_mem[text_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        r_node_q <= node_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= cnt_mem[cnt_raddr];
    end

    ptms_child_mem #(
        .ROWS (NODE_CAP),
        .COLS (ALPHABET),
        .RW   (NW),
        .CW   (CW),
        .DW   (NW)
    ) u_child (
        .i_clk   (i_clk),
        .i_ctl   (child_ctl),
        .i_wrow  (child_wrow),
        .i_wcol  (child_wcol),
        .i_wdata (child_wdata),
        .i_rrow  (r_nd),
        .i_rcol  (r_c),
        .o_rdata (child_q)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.best_score = r_obest;
    assign o_out.overflow   = r_oovf;

    // a stored letter advances the position by one
    `PTMS_ASSERT_NEXT(a_pos_step, i_clk, i_rst_n, accept && r_pos < MAX_POS, r_pos == PW'($past(r_pos) + 1'b1))
    // node count never passes the capacity of the node memories
    `PTMS_ASSERT(a_total_cap, i_clk, i_rst_n, 1'b1, r_total <= NODE_LAST && r_total != '0)
    // a result beat only follows the end of the push-down
    `PTMS_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_ovalid), $past(r_state) == S_DONE)
    // the walk stops only where the letter extends the palindrome
    `PTMS_ASSERT_NEXT(a_walk_match, i_clk, i_rst_n, r_state == S_WC && r_ok && r_text_q == r_c, r_state == S_CD)

endmodule

FILE: tb/palindromic_tree_max_score_test.sv
// self-checking test of the palindromic tree score block
// depends on ptms_pkg, ptms_if and the block's top level; predicts each score beat in place
module palindromic_tree_max_score_test;
    import ptms_pkg::*;

    localparam int STR_CAP  = MAX_LEN_DEF;
    localparam int NODE_CAP = MAX_LEN_DEF + 2;

    typedef struct packed {
        logic [SCORE_W-1:0] best_score;
        logic               overflow;
    } t_score_beat;

    logic i_clk;
    logic i_rst_n;
    ptms_in_if  in_ch ();
    ptms_out_if out_ch ();

    palindromic_tree_max_score dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // predictor state: a software eertree mirroring the block
    int          txt [0:STR_CAP];
    int          kid [0:NODE_CAP-1][0:ALPHABET_DEF-1];
    int          slink [0:NODE_CAP-1];
    int          plen [0:NODE_CAP-1];
    int          pcnt [0:NODE_CAP-1];
    int          cur_node;
    int          n_nodes;
    int          str_pos;
    bit          ovf_seen;

    t_score_beat pending_scores[$];
    int          errors;
    bit          stall_long;   // receiver hold-off request

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400000000;
        $display("tb: failure");
        $finish;
    end

    function automatic void tree_clear();
        for (int k = 0; k <= n_nodes && k < NODE_CAP; k++) begin
            for (int a = 0; a < ALPHABET_DEF; a++) kid[k][a] = 0;
            slink[k] = 0;
            plen[k]  = 0;
            pcnt[k]  = 0;
        end
        for (int p = 0; p <= STR_CAP; p++) txt[p] = 0;
        txt[0]   = -1;
        plen[0]  = -1;
        plen[1]  = 0;
        cur_node = 1;
        n_nodes  = 1;
        str_pos  = 0;
        ovf_seen = 1'b0;
    endfunction

    function automatic bit grows(int nd, int c);
        int idx;
        idx = str_pos - plen[nd] - 1;
        if (idx < 1 || idx > STR_CAP) return 1'b0;
        return txt[idx] == c;
    endfunction

    function automatic void tree_add(int c);
        int nd, sub, nx;
        str_pos++;
        txt[str_pos] = c;
        nd = cur_node;
        while (!grows(nd, c)) nd = slink[nd];
        nx = kid[nd][c];
        if (nx == 0 && n_nodes + 1 < NODE_CAP) begin
            n_nodes++;
            nx = n_nodes;
            plen[nx] = plen[nd] + 2;
            if (plen[nx] == 1) begin
                slink[nx] = 1;
            end else begin
                sub = slink[nd];
                while (!grows(sub, c)) sub = slink[sub];
                slink[nx] = (kid[sub][c] != 0) ? kid[sub][c] : 1;
            end
            kid[nd][c] = nx;
        end
        if (nx == 0) nx = 1;
        pcnt[nx]++;
        cur_node = nx;
    endfunction

    // folds a letter beat into the tree; returns 1 with the score on the last letter
    function automatic bit tree_letter(logic [LETTER_W-1:0] code, logic fin,
                                       output t_score_beat res);
        longint best, sc;
        res = '0;
        if (str_pos < STR_CAP) tree_add(int'(code) % ALPHABET_DEF);
        else ovf_seen = 1'b1;
        if (!fin) return 1'b0;
        best = 0;
        for (int k = n_nodes; k > 1; k--) begin
            pcnt[slink[k]] += pcnt[k];
            sc = longint'(pcnt[k]) * longint'(plen[k]);
            if (sc > best) best = sc;
        end
        res.best_score = (best > longint'(SCORE_MAX)) ? SCORE_MAX : best[SCORE_W-1:0];
        res.overflow   = ovf_seen;
        tree_clear();
        return 1'b1;
    endfunction

    // random gap, mostly short with the odd long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one letter beat, held until accepted; valid drops only in a gap
    task automatic send_letter(logic [LETTER_W-1:0] code, logic fin, bit gaps = 1'b1);
        t_score_beat res;
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.letter <= code;
        in_ch.last   <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (tree_letter(code, fin, res)) pending_scores = {pending_scores, res};
        @(negedge i_clk);
    endtask

    task automatic send_word(int letters[$], bit gaps = 1'b1);
        foreach (letters[i]) send_letter(letters[i][LETTER_W-1:0], i == letters.size() - 1, gaps);
    endtask

    task automatic drain_scores();
        in_ch.valid <= 1'b0;
        while (pending_scores.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // result check at every rising edge with valid and ready high
    initial begin
        t_score_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_scores.size() == 0) begin
                    $display("%0t: unexpected score beat %0d/%0b", $time,
                             out_ch.best_score, out_ch.overflow);
                    errors++;
                end else begin
                    want = pending_scores.pop_front();
                    if (out_ch.best_score !== want.best_score) begin
                        $display("%0t: best_score expected %0d actual %0d", $time,
                                 want.best_score, out_ch.best_score);
                        errors++;
                    end
                    if (out_ch.overflow !== want.overflow) begin
                        $display("%0t: overflow expected %0b actual %0b", $time,
                                 want.overflow, out_ch.overflow);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver back-pressure: random stalls, or a long hold-off on request
    initial begin
        int g;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_long) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                stall_long = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic test_short_words();
        send_word('{0});                    // single letter
        send_word('{25, 25});
        send_word('{0, 1, 0, 1, 0});
        send_word('{2, 0, 1, 0, 2, 0, 1});
        send_word('{26, 31, 0, 5});         // folded letter codes
        send_word('{7, 7, 7, 7, 7, 7, 7, 7});
        drain_scores();
    endtask

    // receiver holds off while letters keep coming
    task automatic test_back_pressure();
        stall_long = 1'b1;
        for (int w = 0; w < 6; w++) send_word('{1, 2, 1});
        drain_scores();
    endtask

    task automatic test_random_words();
        int n, alpha, letters[$];
        for (int sent = 0; sent < 1100;) begin
            letters.delete();
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            alpha = $urandom_range(1, 4) == 1 ? 32 : $urandom_range(1, 3);
            for (int i = 0; i < n; i++) letters = {letters, int'($urandom_range(0, alpha - 1))};
            send_word(letters);
            sent += n;
        end
        drain_scores();
    endtask

    initial begin
        errors       = 0;
        stall_long   = 1'b0;
        n_nodes      = NODE_CAP - 1;
        tree_clear();
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.letter = '0;
        in_ch.last   = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_short_words();
        test_back_pressure();
        test_random_words();
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
